/* rtl/core/hpcs_pkg.sv */
// Shared types and constants for the HV precharge and contactor sequencer.
// Holds sequencer states, fault bit positions, item structs and register map.
// No dependencies.
package hpcs_pkg;

  typedef enum logic [2:0] {
    ST_DEENERGIZED = 3'd0,
    ST_DELAY       = 3'd1,
    ST_PRECHARGING = 3'd2,
    ST_ENERGIZED   = 3'd3,
    ST_DISCHARGING = 3'd4,
    ST_PANIC       = 3'd5
  } ts_state_e;

  typedef enum logic [1:0] {
    RPT_NONE     = 2'd0,
    RPT_STARTED  = 2'd1,
    RPT_COMPLETE = 2'd2
  } report_e;

  typedef enum logic [1:0] {
    REG_DELAY_TICKS     = 2'd0,
    REG_PRECHARGE_TICKS = 2'd1,
    REG_DISCHARGE_TICKS = 2'd2,
    REG_MIN_VOLTAGE     = 2'd3
  } reg_idx_e;

  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned TickW  = 8;
  localparam int unsigned VoltW  = 16;
  localparam int unsigned FaultW = 11;

  localparam int unsigned F_GENERAL     = 0;
  localparam int unsigned F_BMS         = 1;
  localparam int unsigned F_IMD         = 2;
  localparam int unsigned F_APLUS_WELD  = 3;
  localparam int unsigned F_AMINUS_WELD = 4;
  localparam int unsigned F_APLUS_LOSS  = 5;
  localparam int unsigned F_AMINUS_LOSS = 6;
  localparam int unsigned F_STUCK       = 7;
  localparam int unsigned F_PC_LOSS     = 8;
  localparam int unsigned F_DC_LOSS     = 9;
  localparam int unsigned F_INCOMPLETE  = 10;

  localparam logic [TickW-1:0] DelayTicksRst     = 8'h17;
  localparam logic [TickW-1:0] PrechargeTicksRst = 8'h10;
  localparam logic [TickW-1:0] DischargeTicksRst = 8'h1F;
  localparam logic [VoltW-1:0] MinVoltageRst     = 16'h00B4;

  typedef logic [FaultW-1:0] fault_t;

  typedef struct packed {
    logic             kind;
    logic             bms_ok;
    logic             imd_ok;
    logic             aplus_fb;
    logic             aminus_fb;
    logic             tsms_closed;
    logic             sense_mp;
    logic             sense_imd;
    logic             sense_bms;
    logic [VoltW-1:0] mc_voltage;
  } in_item_t;

  typedef struct packed {
    ts_state_e ts_state;
    logic      precharge_on;
    logic      airminus_on;
    fault_t    fault_mask;
    report_e   precharge_report;
  } out_item_t;

  typedef struct packed {
    logic [TickW-1:0] delay_ticks;
    logic [TickW-1:0] precharge_ticks;
    logic [TickW-1:0] discharge_ticks;
    logic [VoltW-1:0] min_voltage;
  } cfg_t;

  typedef struct packed {
    logic   panic;
    fault_t faults;
  } chk_t;

  typedef struct packed {
    ts_state_e state;
    logic      precharge_relay;
    logic      airminus_relay;
  } seq_status_t;

endpackage

/* rtl/core/hpcs_in_if.sv */
// Input channel of the sequencer: valid/ready handshake with a status or tick item.
// Standalone; no package dependency.
interface hpcs_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        bms_ok;
  logic        imd_ok;
  logic        aplus_fb;
  logic        aminus_fb;
  logic        tsms_closed;
  logic        sense_mp;
  logic        sense_imd;
  logic        sense_bms;
  logic [15:0] mc_voltage;

  modport source (
    output valid, kind, bms_ok, imd_ok, aplus_fb, aminus_fb, tsms_closed,
           sense_mp, sense_imd, sense_bms, mc_voltage,
    input  ready
  );

  modport sink (
    input  valid, kind, bms_ok, imd_ok, aplus_fb, aminus_fb, tsms_closed,
           sense_mp, sense_imd, sense_bms, mc_voltage,
    output ready
  );
endinterface

/* rtl/core/hpcs_out_if.sv */
// Result channel of the sequencer: valid/ready handshake with one result item.
// Standalone; no package dependency.
interface hpcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  ts_state;
  logic        precharge_on;
  logic        airminus_on;
  logic [10:0] fault_mask;
  logic [1:0]  precharge_report;

  modport source (
    output valid, ts_state, precharge_on, airminus_on, fault_mask, precharge_report,
    input  ready
  );

  modport sink (
    input  valid, ts_state, precharge_on, airminus_on, fault_mask, precharge_report,
    output ready
  );
endinterface

/* rtl/core/hpcs_cfg.sv */
// APB-style configuration registers: tick thresholds and minimum precharge voltage.
// Depends on hpcs_pkg.
module hpcs_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpcs_pkg::AddrW-1:0] paddr,
  input  logic [hpcs_pkg::DataW-1:0] pwdata,
  output logic [hpcs_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output hpcs_pkg::cfg_t             cfg_o
);
  import hpcs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ticks     <= DelayTicksRst;
      cfg_q.precharge_ticks <= PrechargeTicksRst;
      cfg_q.discharge_ticks <= DischargeTicksRst;
      cfg_q.min_voltage     <= MinVoltageRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_DELAY_TICKS:     cfg_q.delay_ticks     <= pwdata[TickW-1:0];
        REG_PRECHARGE_TICKS: cfg_q.precharge_ticks <= pwdata[TickW-1:0];
        REG_DISCHARGE_TICKS: cfg_q.discharge_ticks <= pwdata[TickW-1:0];
        REG_MIN_VOLTAGE:     cfg_q.min_voltage     <= pwdata[VoltW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DELAY_TICKS:     prdata[TickW-1:0] = cfg_q.delay_ticks;
      REG_PRECHARGE_TICKS: prdata[TickW-1:0] = cfg_q.precharge_ticks;
      REG_DISCHARGE_TICKS: prdata[TickW-1:0] = cfg_q.discharge_ticks;
      REG_MIN_VOLTAGE:     prdata[VoltW-1:0] = cfg_q.min_voltage;
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

/* rtl/core/hpcs_check.sv */
// Plausibility checks on a status item: BMS, IMD, AIR plus and AIR minus.
// Depends on hpcs_pkg.
module hpcs_check (
  input  hpcs_pkg::in_item_t item_i,
  input  logic               airminus_relay_i,
  output hpcs_pkg::chk_t     chk_o
);
  import hpcs_pkg::*;

  fault_t faults;

  always_comb begin
    faults = '0;
    faults[F_BMS] = (item_i.bms_ok & item_i.sense_mp & ~item_i.sense_bms)
                  | (~item_i.bms_ok & item_i.sense_bms);
    faults[F_IMD] = (item_i.imd_ok & item_i.sense_bms & ~item_i.sense_imd)
                  | (~item_i.imd_ok & item_i.sense_imd);
    faults[F_APLUS_WELD]  = item_i.aplus_fb & ~item_i.tsms_closed;
    faults[F_APLUS_LOSS]  = ~item_i.aplus_fb & item_i.tsms_closed;
    faults[F_AMINUS_WELD] = ~airminus_relay_i & item_i.aminus_fb;
    faults[F_AMINUS_LOSS] = airminus_relay_i & ~item_i.aminus_fb;
  end

  assign chk_o.faults = faults;
  assign chk_o.panic  = |faults;
endmodule

/* rtl/core/hpcs_seq.sv */
// Six-state precharge/contactor sequencer with tick counter, relays and report code.
// Depends on hpcs_pkg.
module hpcs_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  hpcs_pkg::in_item_t    item_i,
  input  hpcs_pkg::cfg_t        cfg_i,
  input  hpcs_pkg::chk_t        chk_i,
  output hpcs_pkg::out_item_t   result_o,
  output hpcs_pkg::seq_status_t status_o
);
  import hpcs_pkg::*;

  ts_state_e        state_q, state_d, eff_state;
  logic [TickW-1:0] tick_q, tick_d;
  logic             pc_q, pc_d;
  logic             am_q, am_d;
  report_e          rpt_q, rpt_d;
  fault_t           faults;
  logic             is_status, v_zero, v_above;
  logic             dly_done, pc_done, dc_done;

  assign is_status = ~item_i.kind;
  assign eff_state = chk_i.panic ? ST_PANIC : state_q;
  assign v_zero    = (item_i.mc_voltage == '0);
  assign v_above   = (item_i.mc_voltage > cfg_i.min_voltage);
  assign dly_done  = (tick_q > cfg_i.delay_ticks);
  assign pc_done   = (tick_q > cfg_i.precharge_ticks);
  assign dc_done   = (tick_q > cfg_i.discharge_ticks);

  always_comb begin
    state_d = state_q;
    if (is_status) begin
      state_d = eff_state;
      unique case (eff_state)
        ST_DEENERGIZED: if (item_i.tsms_closed) state_d = ST_DELAY;
        ST_DELAY: begin
          if (!v_zero) state_d = ST_PANIC;
          else if (dly_done) state_d = ST_PRECHARGING;
        end
        ST_PRECHARGING: begin
          if (pc_done) begin
            if (!v_zero && v_above && item_i.aminus_fb) state_d = ST_ENERGIZED;
            else state_d = ST_PANIC;
          end
        end
        ST_ENERGIZED: if (!item_i.tsms_closed) state_d = ST_DISCHARGING;
        ST_DISCHARGING: begin
          if (dc_done) state_d = v_zero ? ST_DEENERGIZED : ST_PANIC;
        end
        default: state_d = ST_PANIC;
      endcase
    end
  end

  always_comb begin
    tick_d = tick_q;
    pc_d   = pc_q;
    am_d   = am_q;
    rpt_d  = rpt_q;
    faults = '0;
    if (!is_status) begin
      tick_d = tick_q + TickW'(1);
    end else begin
      faults = chk_i.faults;
      unique case (eff_state)
        ST_DEENERGIZED: if (item_i.tsms_closed) tick_d = '0;
        ST_DELAY: begin
          if (!v_zero) begin
            faults[F_STUCK] = 1'b1;
          end else if (dly_done) begin
            rpt_d  = RPT_STARTED;
            pc_d   = 1'b1;
            tick_d = '0;
          end
        end
        ST_PRECHARGING: begin
          if (pc_done) begin
            if (v_zero) begin
              faults[F_PC_LOSS] = 1'b1;
            end else if (v_above) begin
              am_d = 1'b1;
              pc_d = 1'b0;
              if (!item_i.aminus_fb) faults[F_AMINUS_LOSS] = 1'b1;
              else rpt_d = RPT_COMPLETE;
            end else begin
              faults[F_INCOMPLETE] = 1'b1;
            end
          end
        end
        ST_ENERGIZED: begin
          if (!item_i.tsms_closed) begin
            am_d   = 1'b0;
            rpt_d  = RPT_NONE;
            tick_d = '0;
          end
        end
        ST_DISCHARGING: if (dc_done && !v_zero) faults[F_DC_LOSS] = 1'b1;
        default: begin
          am_d = 1'b0;
          pc_d = 1'b0;
          faults[F_GENERAL] = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DEENERGIZED;
      tick_q  <= '0;
      pc_q    <= 1'b0;
      am_q    <= 1'b0;
      rpt_q   <= RPT_NONE;
    end else if (advance_i) begin
      state_q <= state_d;
      tick_q  <= tick_d;
      pc_q    <= pc_d;
      am_q    <= am_d;
      rpt_q   <= rpt_d;
    end
  end

  assign result_o.ts_state         = state_d;
  assign result_o.precharge_on     = pc_d;
  assign result_o.airminus_on      = am_d;
  assign result_o.fault_mask       = faults;
  assign result_o.precharge_report = rpt_d;

  assign status_o.state           = state_q;
  assign status_o.precharge_relay = pc_q;
  assign status_o.airminus_relay  = am_q;
endmodule

/* rtl/core/hv_precharge_contactor_sequencer.sv */
// Top level of the HV precharge and contactor sequencer: input register, checks,
// sequencer and result register. Depends on hpcs_pkg, hpcs_in_if, hpcs_out_if,
// hpcs_cfg, hpcs_check and hpcs_seq.
//
// Takes one item per clock while the sink keeps up and returns one result per
// item: the item lands in an input register, one pass of check and
// sequencer logic produces the result, and a result register holds it for the
// sink. The sequencer state advances as the item moves into the result
// register, so a stalled sink stops the input side only once both registers
// hold items. Registers reset to delay 23, precharge 16, discharge 31 ticks
// and minimum voltage 180; write them only while no item is in flight.
module hv_precharge_contactor_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpcs_pkg::AddrW-1:0] paddr,
  input  logic [hpcs_pkg::DataW-1:0] pwdata,
  output logic [hpcs_pkg::DataW-1:0] prdata,
  output logic                       pready,
  hpcs_in_if.sink                    in_i,
  hpcs_out_if.source                 out_o
);
  import hpcs_pkg::*;

  cfg_t        cfg;
  chk_t        chk;
  seq_status_t status;
  in_item_t    in_item;
  in_item_t    s1_item_q;
  logic        s1_valid_q;
  out_item_t   result;
  out_item_t   out_item_q;
  logic        out_valid_q;
  logic        advance;
  logic        in_fire;

  hpcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    in_item.kind        = in_i.kind;
    in_item.bms_ok      = in_i.bms_ok;
    in_item.imd_ok      = in_i.imd_ok;
    in_item.aplus_fb    = in_i.aplus_fb;
    in_item.aminus_fb   = in_i.aminus_fb;
    in_item.tsms_closed = in_i.tsms_closed;
    in_item.sense_mp    = in_i.sense_mp;
    in_item.sense_imd   = in_i.sense_imd;
    in_item.sense_bms   = in_i.sense_bms;
    in_item.mc_voltage  = in_i.mc_voltage;
  end

  assign advance    = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~s1_valid_q | advance;
  assign in_fire    = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (advance) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_item_q <= in_item;
    if (advance) out_item_q <= result;
  end

  hpcs_check u_check (
    .item_i           (s1_item_q),
    .airminus_relay_i (status.airminus_relay),
    .chk_o            (chk)
  );

  hpcs_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item_q),
    .cfg_i     (cfg),
    .chk_i     (chk),
    .result_o  (result),
    .status_o  (status)
  );

  assign out_o.valid            = out_valid_q;
  assign out_o.ts_state         = out_item_q.ts_state;
  assign out_o.precharge_on     = out_item_q.precharge_on;
  assign out_o.airminus_on      = out_item_q.airminus_on;
  assign out_o.fault_mask       = out_item_q.fault_mask;
  assign out_o.precharge_report = out_item_q.precharge_report;

`ifndef SYNTHESIS
  a_panic_absorbing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.state == ST_PANIC |=> status.state == ST_PANIC)
    else $error("sequencer left panic");

  a_relays_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.precharge_relay && status.airminus_relay))
    else $error("precharge and AIR minus relays both closed");

  a_panic_opens_relays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !s1_item_q.kind && status.state == ST_PANIC
    |=> !out_item_q.precharge_on && !out_item_q.airminus_on)
    else $error("status item in panic left a relay closed");

  a_tick_no_faults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_item_q.kind |=> out_item_q.fault_mask == '0)
    else $error("tick item raised faults");
`endif
endmodule
